[rtl/assert_macros.svh]
// Assertion macros used by the port-level checker (bba_checker).
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b in the same cycle
`define ASSERT_IMPLY(lbl, clk, rstn, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) else $error(msg);

// a implies b in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) else $error(msg);

`endif

[rtl/bba_pkg.sv]
// Shared types and codes of the bitmap block allocator.
// No dependencies.
package bba_pkg;

  localparam int unsigned BLK_W = 7;
  localparam int unsigned CNT_W = 6;
  localparam int unsigned ST_W  = 3;

  typedef enum logic [1:0] {
    OP_INVALID,
    OP_MARK,
    OP_ALLOC,
    OP_EMPTY
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_ALLOCATED = 3'd0,
    ST_DONE      = 3'd1,
    ST_NO_SPACE  = 3'd2,
    ST_INVALID   = 3'd3,
    ST_MARKED    = 3'd4
  } status_e;

  typedef struct packed {
    op_e              op;
    logic [BLK_W-1:0] blk;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_q_t;

endpackage

[rtl/bba_front.sv]
// Front end: accepts requests, classifies them and queues them (two entries).
// Depends on bba_pkg.
module bba_front #(
  parameter int unsigned BLK_TOTAL = 128
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  input  logic                      clearing_i,
  input  logic                      kind_i,
  input  logic [bba_pkg::BLK_W-1:0] block_number_i,
  input  logic [bba_pkg::CNT_W-1:0] block_count_i,
  input  logic                      pop_i,
  output logic                      busy_o,
  output bba_pkg::cmd_q_t           head_o
);
  import bba_pkg::*;

  cmd_t       new_cmd;
  cmd_t       slot_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       push;
  logic       pop;

  always_comb begin
    new_cmd.blk = block_number_i;
    new_cmd.cnt = block_count_i;
    if (32'(block_number_i) >= BLK_TOTAL) begin
      new_cmd.op = OP_INVALID;
    end else if (!kind_i) begin
      new_cmd.op = OP_MARK;
    end else if (block_count_i == '0) begin
      new_cmd.op = OP_EMPTY;
    end else begin
      new_cmd.op = OP_ALLOC;
    end
  end

  assign busy_o       = (count_q == 2'd2) || clearing_i;
  assign push         = start && !busy_o;
  assign pop          = pop_i && (count_q != 2'd0);
  assign head_o.valid = (count_q != 2'd0);
  assign head_o.cmd   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= new_cmd;
  end

endmodule

[rtl/bba_back.sv]
// Back end: holds the used/free bitmap, clears it after reset and runs
// mark writes and allocate scans. Depends on bba_pkg.
module bba_back #(
  parameter int unsigned BLK_TOTAL = 128
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bba_pkg::cmd_q_t           head_i,
  output logic                      pop_o,
  output logic                      clearing_o,
  output logic                      result_valid_o,
  output logic [bba_pkg::BLK_W-1:0] allocated_block_o,
  output logic [bba_pkg::ST_W-1:0]  status_o,
  output logic                      last_o
);
  import bba_pkg::*;

  localparam int unsigned AW = $clog2(BLK_TOTAL);
  localparam int unsigned PW = $clog2(BLK_TOTAL + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_DONE
  } state_e;

  state_e           state_q;
  logic [AW-1:0]    clr_q;
  logic [PW-1:0]    pos_q;
  logic [CNT_W-1:0] got_q;
  logic [CNT_W-1:0] want_q;
  logic [CNT_W-1:0] got_inc;
  logic             rd_q;
  logic             res_valid_q;
  logic [BLK_W-1:0] res_blk_q;
  status_e          res_status_q;
  logic             res_last_q;

  logic             mem [BLK_TOTAL];
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic             mem_wd;
  logic [AW-1:0]    mem_ra;

  assign pop_o             = (state_q == S_IDLE) && head_i.valid;
  assign clearing_o        = (state_q == S_CLEAR);
  assign got_inc           = got_q + 1'b1;
  assign mem_ra            = pos_q[AW-1:0];
  assign result_valid_o    = res_valid_q;
  assign allocated_block_o = res_blk_q;
  assign status_o          = res_status_q;
  assign last_o            = res_last_q;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = pos_q[AW-1:0];
    mem_wd = 1'b1;
    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = 1'b0;
      end
      S_IDLE: begin
        if (pop_o && (head_i.cmd.op == OP_MARK)) begin
          mem_we = 1'b1;
          mem_wa = AW'(head_i.cmd.blk);
        end
      end
      S_CHECK: begin
        mem_we = !rd_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      pos_q        <= '0;
      got_q        <= '0;
      want_q       <= '0;
      res_valid_q  <= 1'b0;
      res_blk_q    <= '0;
      res_status_q <= ST_DONE;
      res_last_q   <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(BLK_TOTAL - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (pop_o) begin
            case (head_i.cmd.op)
              OP_INVALID: begin
                res_valid_q  <= 1'b1;
                res_blk_q    <= '0;
                res_status_q <= ST_INVALID;
                res_last_q   <= 1'b1;
              end
              OP_MARK: begin
                res_valid_q  <= 1'b1;
                res_blk_q    <= '0;
                res_status_q <= ST_MARKED;
                res_last_q   <= 1'b1;
              end
              OP_EMPTY: begin
                res_valid_q  <= 1'b1;
                res_blk_q    <= '0;
                res_status_q <= ST_DONE;
                res_last_q   <= 1'b1;
              end
              OP_ALLOC: begin
                pos_q   <= PW'(head_i.cmd.blk);
                got_q   <= '0;
                want_q  <= head_i.cmd.cnt;
                state_q <= S_READ;
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          if (pos_q >= PW'(BLK_TOTAL)) begin
            res_valid_q  <= 1'b1;
            res_blk_q    <= '0;
            res_status_q <= ST_NO_SPACE;
            res_last_q   <= 1'b1;
            state_q      <= S_IDLE;
          end else begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          pos_q <= pos_q + 1'b1;
          if (!rd_q) begin
            res_valid_q  <= 1'b1;
            res_blk_q    <= BLK_W'(pos_q);
            res_status_q <= ST_ALLOCATED;
            res_last_q   <= 1'b0;
            got_q        <= got_inc;
            state_q      <= (got_inc == want_q) ? S_DONE : S_READ;
          end else begin
            state_q <= S_READ;
          end
        end
        S_DONE: begin
          res_valid_q  <= 1'b1;
          res_blk_q    <= '0;
          res_status_q <= ST_DONE;
          res_last_q   <= 1'b1;
          state_q      <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/bitmap_block_allocator_core.sv]
// Top level of the bitmap block allocator: request queue plus scan engine.
// Depends on bba_pkg, bba_front, bba_back.
//
//   channel   handshake                 payload
//   request   start / busy              kind_i, block_number_i, block_count_i
//   result    result_valid_o (strobe)   allocated_block_o, status_o, last_o
//
// After reset busy stays high while the bitmap is cleared.
// Mark, invalid and zero-count requests: queued, dequeued, then the result is registered.
// An allocation is dequeued, then each block scanned takes a registered bitmap read,
// then a check and write, and a final result ends it.
// Two requests queue ahead of the engine; busy is high when the queue is full.
// Results are strobed for one cycle and cannot be held off.
module bitmap_block_allocator_core #(
  parameter int unsigned BLK_TOTAL = 128
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic                      kind_i,
  input  logic [bba_pkg::BLK_W-1:0] block_number_i,
  input  logic [bba_pkg::CNT_W-1:0] block_count_i,
  output logic                      result_valid_o,
  output logic [bba_pkg::BLK_W-1:0] allocated_block_o,
  output logic [bba_pkg::ST_W-1:0]  status_o,
  output logic                      last_o
);
  import bba_pkg::*;

  cmd_q_t head;
  logic   pop;
  logic   clearing;

  bba_front #(
    .BLK_TOTAL(BLK_TOTAL)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .clearing_i     (clearing),
    .kind_i         (kind_i),
    .block_number_i (block_number_i),
    .block_count_i  (block_count_i),
    .pop_i          (pop),
    .busy_o         (busy),
    .head_o         (head)
  );

  bba_back #(
    .BLK_TOTAL(BLK_TOTAL)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_i            (head),
    .pop_o             (pop),
    .clearing_o        (clearing),
    .result_valid_o    (result_valid_o),
    .allocated_block_o (allocated_block_o),
    .status_o          (status_o),
    .last_o            (last_o)
  );

endmodule

[rtl/bba_checker.sv]
// Port-level checks of the allocator core, bound to the top level.
// Depends on bba_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bba_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      result_valid_o,
  input logic [bba_pkg::BLK_W-1:0] allocated_block_o,
  input logic [bba_pkg::ST_W-1:0]  status_o,
  input logic                      last_o
);
  import bba_pkg::*;

  `ASSERT_IMPLY(a_final_is_last, clk_i, rst_ni,
    result_valid_o && (status_o != ST_ALLOCATED), last_o, "final status without last")
  `ASSERT_IMPLY(a_alloc_not_last, clk_i, rst_ni,
    result_valid_o && (status_o == ST_ALLOCATED), !last_o, "allocated block marked last")
  `ASSERT_IMPLY(a_blk_zero, clk_i, rst_ni,
    result_valid_o && (status_o != ST_ALLOCATED), allocated_block_o == '0,
    "block index set on a non-allocation result")
  `ASSERT_NEXT(a_alloc_then_end, clk_i, rst_ni,
    result_valid_o && (status_o == ST_ALLOCATED),
    !result_valid_o || (status_o == ST_DONE) || (status_o == ST_NO_SPACE),
    "unexpected result right after an allocated block")

endmodule

bind bitmap_block_allocator_core bba_checker u_bba_checker (.*);

[sim/bitmap_block_allocator_checker.sv]
// Checker for the bitmap block allocator: models the used/free bitmap, predicts the
// results of every accepted request and compares them with the strobed results.
// Depends on bba_pkg.
module bitmap_block_allocator_checker #(
  parameter int unsigned BLK_TOTAL = 128
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  input  logic                      busy,
  input  logic                      kind_i,
  input  logic [bba_pkg::BLK_W-1:0] block_number_i,
  input  logic [bba_pkg::CNT_W-1:0] block_count_i,
  input  logic                      result_valid_o,
  input  logic [bba_pkg::BLK_W-1:0] allocated_block_o,
  input  logic [bba_pkg::ST_W-1:0]  status_o,
  input  logic                      last_o,
  output int                        errors,
  output int                        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  localparam logic KIND_MARK = 1'b0;

  typedef struct {
    logic [BLK_W-1:0] blk;
    status_e          st;
    logic             is_last;
  } alloc_result_t;

  alloc_result_t due_results[$];
  bit            taken[BLK_TOTAL];
  int            fail_cnt = 0;

  function automatic void push_result(logic [BLK_W-1:0] blk, status_e st, logic is_last);
    alloc_result_t r;
    r.blk     = blk;
    r.st      = st;
    r.is_last = is_last;
    due_results.push_back(r);
  endfunction

  // Walks the bitmap exactly as the allocator does; no rollback on out of space.
  function automatic void apply_request(logic kind, logic [BLK_W-1:0] first,
                                        logic [CNT_W-1:0] want);
    int unsigned pos;
    int unsigned got;
    pos = first;
    got = 0;
    if (first >= BLK_TOTAL) begin
      push_result('0, ST_INVALID, 1'b1);
      return;
    end
    if (kind == KIND_MARK) begin
      taken[first] = 1'b1;
      push_result('0, ST_MARKED, 1'b1);
      return;
    end
    while (got < want) begin
      if (pos >= BLK_TOTAL) begin
        push_result('0, ST_NO_SPACE, 1'b1);
        return;
      end
      if (!taken[pos]) begin
        taken[pos] = 1'b1;
        push_result(BLK_W'(pos), ST_ALLOCATED, 1'b0);
        got++;
      end
      pos++;
    end
    push_result('0, ST_DONE, 1'b1);
  endfunction

  function automatic void check_result();
    alloc_result_t r;
    if (due_results.size() == 0) begin
      if (fail_cnt < 10)
        $display("%0t: unexpected result block=%0d status=%0d last=%0d",
                 $realtime, allocated_block_o, status_o, last_o);
      fail_cnt++;
      return;
    end
    r = due_results.pop_front();
    if (status_o !== r.st || allocated_block_o !== r.blk || last_o !== r.is_last) begin
      if (fail_cnt < 10)
        $display({"%0t: mismatch exp block=%0d status=%0d last=%0d,",
                  " got block=%0d status=%0d last=%0d"},
                 $realtime, r.blk, r.st, r.is_last, allocated_block_o, status_o, last_o);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy)
        apply_request(kind_i, block_number_i, block_count_i);
      if (result_valid_o)
        check_result();
    end
    errors      <= fail_cnt;
    outstanding <= due_results.size();
  end

endmodule

[sim/bitmap_block_allocator_core_tb.sv]
// Testbench top for bitmap_block_allocator_core: drives directed and random mark and
// allocate requests, and reports the verdict. Depends on bba_pkg, the RTL and
// bitmap_block_allocator_checker.
module bitmap_block_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  localparam int unsigned BLK_TOTAL    = 128;
  localparam int unsigned RANDOM_ITEMS = 197;
  localparam logic        KIND_MARK    = 1'b0;
  localparam logic        KIND_ALLOC   = 1'b1;

  logic             clk_i;
  logic             rst_ni         = 1'b0;
  logic             start          = 1'b0;
  logic             busy;
  logic             kind_i         = KIND_MARK;
  logic [BLK_W-1:0] block_number_i = '0;
  logic [CNT_W-1:0] block_count_i  = '0;
  logic             result_valid_o;
  logic [BLK_W-1:0] allocated_block_o;
  logic [ST_W-1:0]  status_o;
  logic             last_o;
  int               errors;
  int               outstanding;

  bitmap_block_allocator_core #(.BLK_TOTAL(BLK_TOTAL)) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .kind_i           (kind_i),
    .block_number_i   (block_number_i),
    .block_count_i    (block_count_i),
    .result_valid_o   (result_valid_o),
    .allocated_block_o(allocated_block_o),
    .status_o         (status_o),
    .last_o           (last_o)
  );

  bitmap_block_allocator_checker #(.BLK_TOTAL(BLK_TOTAL)) alloc_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .kind_i           (kind_i),
    .block_number_i   (block_number_i),
    .block_count_i    (block_count_i),
    .result_valid_o   (result_valid_o),
    .allocated_block_o(allocated_block_o),
    .status_o         (status_o),
    .last_o           (last_o),
    .errors           (errors),
    .outstanding      (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("bitmap_block_allocator_core_tb: done, errors");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic request(input logic kind, input logic [BLK_W-1:0] blk,
                         input logic [CNT_W-1:0] cnt);
    start          <= 1'b1;
    kind_i         <= kind;
    block_number_i <= blk;
    block_count_i  <= cnt;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic pause(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  initial begin
    logic             kind;
    logic [BLK_W-1:0] blk;
    logic [CNT_W-1:0] cnt;
    int unsigned      pick;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: zero count, repeated mark, skip over used, count met at the end,
    // out of space with and without allocations, full-width count
    request(KIND_ALLOC, 7'd0,   6'd0);
    request(KIND_MARK,  7'd0,   6'd0);
    request(KIND_MARK,  7'd0,   6'd63);
    request(KIND_ALLOC, 7'd0,   6'd3);
    request(KIND_ALLOC, 7'd126, 6'd2);
    request(KIND_ALLOC, 7'd127, 6'd1);
    request(KIND_MARK,  7'd127, 6'd0);
    request(KIND_ALLOC, 7'd127, 6'd0);
    request(KIND_ALLOC, 7'd120, 6'd10);
    request(KIND_ALLOC, 7'd96,  6'd63);
    request(KIND_MARK,  7'd64,  6'd63);
    request(KIND_ALLOC, 7'd60,  6'd5);
    request(KIND_MARK,  7'd85,  6'd42);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind = ($urandom_range(0, 99) < 75) ? KIND_ALLOC : KIND_MARK;
      blk  = BLK_W'($urandom_range(0, BLK_TOTAL - 1));
      pick = $urandom_range(0, 99);
      if (pick < 75)
        cnt = CNT_W'($urandom_range(0, 2));
      else if (pick < 93)
        cnt = CNT_W'($urandom_range(3, 12));
      else
        cnt = CNT_W'($urandom_range(13, 63));
      if (!(i >= 80 && i < 140) && $urandom_range(0, 99) < 10)
        pause($urandom_range(1, 6));
      request(kind, blk, cnt);
    end
    start <= 1'b0;

    while (outstanding != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && outstanding == 0) begin
      $display("bitmap_block_allocator_core_tb: done, clean");
    end else begin
      $display("bitmap_block_allocator_core_tb: done, errors");
    end
    $finish;
  end

endmodule
